// ===== design/aap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aap_pkg
// shared types, widths and constants for the axis-angle point rotation
// ----------------------------------------------------------------------------
package aap_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_WIDTH  = 32;

  localparam int AXIS_W   = 16;
  localparam int ANGLE_W  = 17;
  localparam int ANG_W    = 18;
  localparam int CS_W     = 34;
  localparam int Z_W      = 33;
  localparam int AB_W     = 32;
  localparam int OMC_W    = 35;
  localparam int ABO_W    = AB_W + OMC_W;
  localparam int VS_W     = AXIS_W + CS_W;
  localparam int ACC_W    = 68;
  localparam int EL_SHIFT = 34;
  localparam int ELEM_W   = ACC_W - EL_SHIFT;
  localparam int MAT_FRAC = 24;
  localparam int PX_W     = (COORD_WIDTH > MAT_FRAC) ? COORD_WIDTH : MAT_FRAC + 1;
  localparam int PH_W     = PX_W - MAT_FRAC;
  localparam int PHP_W    = ELEM_W + PH_W;
  localparam int PLP_W    = ELEM_W + MAT_FRAC + 1;
  localparam int HI_W     = PHP_W + 2;
  localparam int LO_W     = PLP_W + 2;
  localparam int R_W      = HI_W + 1;
  localparam int PIPE_LAT = CORDIC_STEPS + 7;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(46080);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(23040);
  localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(92160);
  localparam logic signed [CS_W-1:0]  CORDIC_GAIN  = CS_W'(652032874);
  localparam logic signed [CS_W-1:0]  ONE_Q30      = CS_W'(64'sd1 <<< 30);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]      axis_t;
  typedef logic signed [AB_W-1:0]        ab_t;
  typedef logic signed [ELEM_W-1:0]      elem_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    axis_t  vx;
    axis_t  vy;
    axis_t  vz;
  } item_t;

  typedef struct packed {
    ab_t xx;
    ab_t xy;
    ab_t xz;
    ab_t yy;
    ab_t yz;
    ab_t zz;
  } abp_t;

  // row major, element r*3+k
  typedef elem_t [8:0] mat_t;

  // arctangent of 2^-i in 2^-24 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = Z_W'(754974720);
      1:  v = Z_W'(445687602);
      2:  v = Z_W'(235489088);
      3:  v = Z_W'(119537938);
      4:  v = Z_W'(60000934);
      5:  v = Z_W'(30029717);
      6:  v = Z_W'(15018523);
      7:  v = Z_W'(7509720);
      8:  v = Z_W'(3754917);
      9:  v = Z_W'(1877466);
      10: v = Z_W'(938734);
      11: v = Z_W'(469367);
      12: v = Z_W'(234684);
      13: v = Z_W'(117342);
      14: v = Z_W'(58671);
      15: v = Z_W'(29335);
      16: v = Z_W'(14668);
      17: v = Z_W'(7334);
      18: v = Z_W'(3667);
      19: v = Z_W'(1833);
      20: v = Z_W'(917);
      21: v = Z_W'(458);
      22: v = Z_W'(229);
      23: v = Z_W'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/aap_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aap_cordic
// angle folding, pipelined degree cordic and one-minus-cosine
// ----------------------------------------------------------------------------
module aap_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  aap_pkg::item_t                 in_item,
  input  logic signed [aap_pkg::ANGLE_W-1:0] in_angle,
  output logic                           out_valid,
  output aap_pkg::item_t                 out_item,
  output aap_pkg::abp_t                  out_abp,
  output logic signed [aap_pkg::CS_W-1:0]  cos_v,
  output logic signed [aap_pkg::CS_W-1:0]  sin_v,
  output logic signed [aap_pkg::OMC_W-1:0] omc
);
  import aap_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [ANG_W-1:0] ang_w;
  logic signed [ANG_W-1:0] ang_f;
  logic                    neg_f;
  abp_t                    abp_in;

  logic                    vld [0:N];
  logic                    neg [0:N];
  item_t                   itm [0:N];
  abp_t                    abp [0:N];
  logic signed [CS_W-1:0]  cx  [0:N];
  logic signed [CS_W-1:0]  cy  [0:N];
  logic signed [Z_W-1:0]   cz  [0:N];

  // wrap once by a full turn, then fold into a quarter turn
  always_comb begin
    ang_w = ANG_W'(in_angle);
    if (ang_w > HALF_TURN) begin
      ang_w = ang_w - FULL_TURN;
    end else if (ang_w < -HALF_TURN) begin
      ang_w = ang_w + FULL_TURN;
    end
    ang_f = ang_w;
    neg_f = 1'b0;
    if (ang_w > QUARTER_TURN) begin
      ang_f = ang_w - HALF_TURN;
      neg_f = 1'b1;
    end else if (ang_w < -QUARTER_TURN) begin
      ang_f = ang_w + HALF_TURN;
      neg_f = 1'b1;
    end
  end

  always_comb begin
    abp_in.xx = AB_W'(in_item.vx * in_item.vx);
    abp_in.xy = AB_W'(in_item.vx * in_item.vy);
    abp_in.xz = AB_W'(in_item.vx * in_item.vz);
    abp_in.yy = AB_W'(in_item.vy * in_item.vy);
    abp_in.yz = AB_W'(in_item.vy * in_item.vz);
    abp_in.zz = AB_W'(in_item.vz * in_item.vz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    neg[0] <= neg_f;
    itm[0] <= in_item;
    abp[0] <= abp_in;
    cx[0]  <= CORDIC_GAIN;
    cy[0]  <= '0;
    cz[0]  <= Z_W'(ang_f) <<< 16;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      neg[i+1] <= neg[i];
      itm[i+1] <= itm[i];
      abp[i+1] <= abp[i];
      if (!cz[i][Z_W-1]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - atan_q24(i);
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + atan_q24(i);
      end
    end
  end

  logic signed [CS_W-1:0] c_fix;
  logic signed [CS_W-1:0] s_fix;

  assign c_fix = neg[N] ? -cx[N] : cx[N];
  assign s_fix = neg[N] ? -cy[N] : cy[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[N];
    end
    out_item <= itm[N];
    out_abp  <= abp[N];
    cos_v    <= c_fix;
    sin_v    <= s_fix;
    omc      <= OMC_W'(ONE_Q30) - OMC_W'(c_fix);
  end

endmodule

// ===== design/aap_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aap_matrix
// rodrigues matrix elements, two stages: products then rounded sums
// ----------------------------------------------------------------------------
module aap_matrix (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  aap_pkg::item_t                   in_item,
  input  aap_pkg::abp_t                    in_abp,
  input  logic signed [aap_pkg::CS_W-1:0]  cos_v,
  input  logic signed [aap_pkg::CS_W-1:0]  sin_v,
  input  logic signed [aap_pkg::OMC_W-1:0] omc,
  output logic                             out_valid,
  output aap_pkg::item_t                   out_item,
  output aap_pkg::mat_t                    out_mat
);
  import aap_pkg::*;

  logic signed [ABO_W-1:0] abo [0:5];
  logic signed [VS_W-1:0]  xs;
  logic signed [VS_W-1:0]  ys;
  logic signed [VS_W-1:0]  zs;
  logic signed [CS_W-1:0]  c_d;
  logic                    m1_valid;
  item_t                   m1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= in_valid;
    end
    m1_item <= in_item;
    c_d     <= cos_v;
    abo[0]  <= ABO_W'(in_abp.xx) * ABO_W'(omc);
    abo[1]  <= ABO_W'(in_abp.xy) * ABO_W'(omc);
    abo[2]  <= ABO_W'(in_abp.xz) * ABO_W'(omc);
    abo[3]  <= ABO_W'(in_abp.yy) * ABO_W'(omc);
    abo[4]  <= ABO_W'(in_abp.yz) * ABO_W'(omc);
    abo[5]  <= ABO_W'(in_abp.zz) * ABO_W'(omc);
    xs      <= VS_W'(in_item.vx) * VS_W'(sin_v);
    ys      <= VS_W'(in_item.vy) * VS_W'(sin_v);
    zs      <= VS_W'(in_item.vz) * VS_W'(sin_v);
  end

  function automatic elem_t make_elem(input logic signed [ABO_W-1:0] a,
                                      input logic signed [VS_W-1:0]  ds,
                                      input logic signed [CS_W-1:0]  c,
                                      input logic                    diag);
    logic signed [ACC_W-1:0] acc;
    acc = ACC_W'(a) + (ACC_W'(ds) <<< 14) + (ACC_W'(1) <<< (EL_SHIFT - 1));
    if (diag) begin
      acc = acc + (ACC_W'(c) <<< 28);
    end
    return acc[ACC_W-1:EL_SHIFT];
  endfunction

  mat_t mat_next;

  always_comb begin
    mat_next[0] = make_elem(abo[0], '0,  c_d, 1'b1);
    mat_next[1] = make_elem(abo[1], -zs, c_d, 1'b0);
    mat_next[2] = make_elem(abo[2], ys,  c_d, 1'b0);
    mat_next[3] = make_elem(abo[1], zs,  c_d, 1'b0);
    mat_next[4] = make_elem(abo[3], '0,  c_d, 1'b1);
    mat_next[5] = make_elem(abo[4], -xs, c_d, 1'b0);
    mat_next[6] = make_elem(abo[2], -ys, c_d, 1'b0);
    mat_next[7] = make_elem(abo[4], xs,  c_d, 1'b0);
    mat_next[8] = make_elem(abo[5], '0,  c_d, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= m1_valid;
    end
    out_item <= m1_item;
    out_mat  <= mat_next;
  end

endmodule

// ===== design/aap_apply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aap_apply
// matrix times point in split high and low parts, rounding and saturation
// ----------------------------------------------------------------------------
module aap_apply (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  aap_pkg::item_t       in_item,
  input  aap_pkg::mat_t        in_mat,
  output logic                 out_valid,
  output aap_pkg::coord_t      out_x,
  output aap_pkg::coord_t      out_y,
  output aap_pkg::coord_t      out_z
);
  import aap_pkg::*;

  logic signed [PX_W-1:0]  pext [0:2];
  logic signed [PH_W-1:0]  ph   [0:2];
  logic [MAT_FRAC-1:0]     pl   [0:2];

  assign pext[0] = PX_W'(in_item.px);
  assign pext[1] = PX_W'(in_item.py);
  assign pext[2] = PX_W'(in_item.pz);

  for (genvar k = 0; k < 3; k++) begin : g_split
    assign ph[k] = pext[k][PX_W-1:MAT_FRAC];
    assign pl[k] = pext[k][MAT_FRAC-1:0];
  end

  logic signed [PHP_W-1:0] hp [0:8];
  logic signed [PLP_W-1:0] lp [0:8];
  logic                    m3_valid;

  for (genvar e = 0; e < 9; e++) begin : g_prod
    always_ff @(posedge clk) begin
      hp[e] <= PHP_W'($signed(in_mat[e])) * PHP_W'(ph[e % 3]);
      lp[e] <= PLP_W'($signed(in_mat[e])) * $signed({{(PLP_W-MAT_FRAC){1'b0}}, pl[e % 3]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= in_valid;
    end
  end

  logic signed [HI_W-1:0] hi [0:2];
  logic signed [LO_W-1:0] lo [0:2];
  logic                   m4_valid;

  for (genvar r = 0; r < 3; r++) begin : g_sum
    always_ff @(posedge clk) begin
      hi[r] <= HI_W'(hp[3*r]) + HI_W'(hp[3*r+1]) + HI_W'(hp[3*r+2]);
      lo[r] <= LO_W'(lp[3*r]) + LO_W'(lp[3*r+1]) + LO_W'(lp[3*r+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else begin
      m4_valid <= m3_valid;
    end
  end

  coord_t sat [0:2];

  for (genvar r = 0; r < 3; r++) begin : g_sat
    logic signed [LO_W-1:0] lo_rnd;
    logic signed [R_W-1:0]  rsum;
    logic                   fits;
    assign lo_rnd = (lo[r] + (LO_W'(1) <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
    assign rsum   = R_W'(hi[r]) + R_W'($signed(lo_rnd[LO_W-MAT_FRAC-1:0]));
    assign fits   = (&rsum[R_W-1:COORD_WIDTH-1]) | ~(|rsum[R_W-1:COORD_WIDTH-1]);
    always_comb begin
      if (fits) begin
        sat[r] = rsum[COORD_WIDTH-1:0];
      end else if (rsum[R_W-1]) begin
        sat[r] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        sat[r] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= m4_valid;
    end
    out_x <= sat[0];
    out_y <= sat[1];
    out_z <= sat[2];
  end

endmodule

// ===== design/axis_angle_point_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_point_rotation
// rotates a point about a unit axis through the origin by a signed angle
// throughput: one transfer every cycle; busy is always low and done cannot stall
// reset clears only the valid bits of the pipeline, no results are in flight after
// ----------------------------------------------------------------------------
module axis_angle_point_rotation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [aap_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [aap_pkg::COORD_WIDTH-1:0] point_y,
  input  logic signed [aap_pkg::COORD_WIDTH-1:0] point_z,
  input  logic signed [aap_pkg::AXIS_W-1:0]      axis_x,
  input  logic signed [aap_pkg::AXIS_W-1:0]      axis_y,
  input  logic signed [aap_pkg::AXIS_W-1:0]      axis_z,
  input  logic signed [aap_pkg::ANGLE_W-1:0]     angle_deg,
  output logic                                done,
  output logic signed [aap_pkg::COORD_WIDTH-1:0] rotated_x,
  output logic signed [aap_pkg::COORD_WIDTH-1:0] rotated_y,
  output logic signed [aap_pkg::COORD_WIDTH-1:0] rotated_z
);
  import aap_pkg::*;

  // every stage advances every cycle, so a transfer is never refused
  assign busy = 1'b0;

  item_t in_item;
  assign in_item.px = point_x;
  assign in_item.py = point_y;
  assign in_item.pz = point_z;
  assign in_item.vx = axis_x;
  assign in_item.vy = axis_y;
  assign in_item.vz = axis_z;

  // cordic stage: fold angle, one rotation per register, negate on fold
  logic                    cs_valid;
  item_t                   cs_item;
  abp_t                    cs_abp;
  logic signed [CS_W-1:0]  cs_cos;
  logic signed [CS_W-1:0]  cs_sin;
  logic signed [OMC_W-1:0] cs_omc;

  aap_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .in_item   (in_item),
    .in_angle  (angle_deg),
    .out_valid (cs_valid),
    .out_item  (cs_item),
    .out_abp   (cs_abp),
    .cos_v     (cs_cos),
    .sin_v     (cs_sin),
    .omc       (cs_omc)
  );

  // matrix elements in q.24, rounded half up
  logic  mx_valid;
  item_t mx_item;
  mat_t  mx_mat;

  aap_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cs_valid),
    .in_item   (cs_item),
    .in_abp    (cs_abp),
    .cos_v     (cs_cos),
    .sin_v     (cs_sin),
    .omc       (cs_omc),
    .out_valid (mx_valid),
    .out_item  (mx_item),
    .out_mat   (mx_mat)
  );

  // row products, sums, rounding and saturation to the coordinate range
  aap_apply u_apply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mx_valid),
    .in_item   (mx_item),
    .in_mat    (mx_mat),
    .out_valid (done),
    .out_x     (rotated_x),
    .out_y     (rotated_y),
    .out_z     (rotated_z)
  );

`ifndef ASSERT_OFF
  // every accepted transfer surfaces after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("accepted transfer did not complete on time");

  // no result without an accepted transfer at the matching earlier edge
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching transfer");
`endif

endmodule
